### rtl/kcm_pkg.sv
`default_nettype none
package kcm_pkg;

  typedef enum logic [2:0] {
    OP_KEY_DOWN  = 3'd0,
    OP_KEY_UP    = 3'd1,
    OP_CANCEL    = 3'd2,
    OP_TICK      = 3'd3,
    OP_SUBSCRIBE = 3'd4,
    OP_UNSUB     = 3'd5,
    OP_DROP      = 3'd6,
    OP_NONE      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOT_FND  = 2'd3
  } status_e;

  typedef enum logic {
    ACT_DOWN = 1'b0,
    ACT_UP   = 1'b1
  } act_e;

  typedef enum logic {
    KIND_NOTIFY = 1'b0,
    KIND_CLOSE  = 1'b1
  } kind_e;

  localparam int unsigned KeyW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned SessW = 8;
  localparam int unsigned CntW  = 3;

  // One accepted command as handed from the front end to the back end.
  typedef struct packed {
    op_e              op;
    logic [KeyW-1:0]  key;
    logic [KeyW-1:0]  key_a;
    logic [KeyW-1:0]  key_b;
    logic [KeyW-1:0]  key_c;
    logic [KeyW-1:0]  key_d;
    logic [CntW-1:0]  cnt;
    logic [SessW-1:0] sess;
    logic [KeyW-1:0]  id;
    logic             press;
    logic [TimeW-1:0] tval;
    logic [TimeW-1:0] dtime;
    logic             late;     // signed (tval - dtime) is negative
    logic             cnt_bad;  // more pre-keys than a slot can hold
  } cmd_t;

  // One result transfer.
  typedef struct packed {
    kind_e            kind;
    logic [KeyW-1:0]  id;
    logic [SessW-1:0] sess;
    logic [KeyW-1:0]  key;
    act_e             act;
    logic [TimeW-1:0] tim;
    logic             handled;
    status_e          status;
    logic             last;
  } res_t;

  typedef enum logic [1:0] {
    BE_IDLE  = 2'd0,
    BE_SCAN  = 2'd1,
    BE_CLOSE = 2'd2
  } be_state_e;

endpackage
`default_nettype wire

### rtl/kcm_front.sv
`default_nettype none
// Front end: takes commands, classifies them and keeps a small queue for the back end.
module kcm_front #(
  parameter int unsigned Depth = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire kcm_pkg::cmd_t cmd_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              avail_o,
  output kcm_pkg::cmd_t     cmd_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  kcm_pkg::cmd_t    mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  kcm_pkg::cmd_t    cls;

  // classification: sign of elapsed time, overfull pre-key list
  // the signed difference tval - dtime is negative exactly when tval < dtime
  always_comb begin
    cls         = cmd_i;
    cls.late    = (cmd_i.tval < cmd_i.dtime);
    cls.cnt_bad = (cmd_i.cnt > kcm_pkg::CntW'(4));
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cls;
    end
  end

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign avail_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
endmodule
`default_nettype wire

### rtl/kcm_back.sv
`default_nettype none
// Back end: slot table, one slot visited per cycle, then the closing status.
module kcm_back #(
  parameter int unsigned Slots  = 8,
  parameter int unsigned MaxPre = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          avail_i,
  input  wire kcm_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               res_vld_o,
  output kcm_pkg::res_t      res_o
);
  localparam int unsigned SW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned KW = kcm_pkg::KeyW;
  localparam int unsigned TW = kcm_pkg::TimeW;

  // slot table
  logic [Slots-1:0]          valid_q;
  logic [Slots-1:0]          ton_q;
  logic [TW-1:0]             rem_q   [Slots];
  logic [KW-1:0]             id_q    [Slots];
  logic [kcm_pkg::SessW-1:0] sess_q  [Slots];
  logic [KW-1:0]             fkey_q  [Slots];
  logic                      press_q [Slots];
  logic [TW-1:0]             hold_q  [Slots];
  logic [4*KW-1:0]           pre_q   [Slots];
  logic [kcm_pkg::CntW-1:0]  pcnt_q  [Slots];
  logic [KW-1:0]             ekey_q  [Slots];
  logic [TW-1:0]             etime_q [Slots];

  kcm_pkg::be_state_e state_q, state_d;
  kcm_pkg::cmd_t      cmd_q;
  logic [SW-1:0]      idx_q, idx_d;
  logic               handled_q, handled_d;
  logic               done_q, done_d;  // subscribe/unsubscribe found its slot
  kcm_pkg::res_t      res_d, res_q;
  logic               rv_d, rv_q;

  // per-slot work for the slot under the scan index
  logic               sv, sp, keyok, preok, notify, wr_slot, clr_tmr, arm, free;
  logic               dec;
  logic [TW-1:0]      remm1;
  logic [KW-1:0]      held [4];
  logic [3:0]         hit;
  logic [TW-1:0]      dlt;
  logic               lt;

  always_comb begin
    held[0] = cmd_q.key_a;
    held[1] = cmd_q.key_b;
    held[2] = cmd_q.key_c;
    held[3] = cmd_q.key_d;
    sv      = valid_q[idx_q];
    sp      = press_q[idx_q];
    keyok   = (cmd_q.key == fkey_q[idx_q]);
    for (int i = 0; i < 4; i++) begin
      hit[i] = (i >= int'(cmd_q.cnt));
      for (int j = 0; j < 4; j++) begin
        if ((j < int'(cmd_q.cnt)) && (pre_q[idx_q][16*j +: 16] == held[i])) begin
          hit[i] = 1'b1;
        end
      end
    end
    preok = !cmd_q.cnt_bad && (cmd_q.cnt == pcnt_q[idx_q]) && (&hit);
    // signed tval - dtime < hold, with hold unsigned
    dlt   = cmd_q.tval - cmd_q.dtime;
    lt    = cmd_q.late || (dlt < hold_q[idx_q]);
    remm1 = rem_q[idx_q] - 1'b1;
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    handled_d = handled_q;
    done_d    = done_q;
    pop_o     = 1'b0;
    rv_d      = 1'b0;
    res_d     = '0;
    notify    = 1'b0;
    wr_slot   = 1'b0;
    clr_tmr   = 1'b0;
    arm       = 1'b0;
    free      = 1'b0;
    dec       = 1'b0;
    res_d.kind   = kcm_pkg::KIND_NOTIFY;
    res_d.act    = kcm_pkg::ACT_DOWN;
    res_d.status = kcm_pkg::ST_OK;
    res_d.id     = id_q[idx_q];
    res_d.sess   = sess_q[idx_q];
    res_d.key    = cmd_q.key;
    res_d.tim    = cmd_q.tval;
    case (state_q)
      kcm_pkg::BE_IDLE: begin
        if (avail_i) begin
          pop_o     = 1'b1;
          idx_d     = '0;
          handled_d = 1'b0;
          done_d    = 1'b0;
          state_d   = kcm_pkg::BE_SCAN;
        end
      end
      kcm_pkg::BE_SCAN: begin
        case (cmd_q.op)
          kcm_pkg::OP_KEY_DOWN: begin
            if (sv && sp) begin
              if (!keyok || !preok) begin
                clr_tmr = 1'b1;
              end else if (hold_q[idx_q] == '0) begin
                notify = 1'b1;
              end else if (!ton_q[idx_q]) begin
                arm = 1'b1;
              end
            end
          end
          kcm_pkg::OP_KEY_UP: begin
            if (sv && sp) begin
              clr_tmr = 1'b1;
            end else if (sv && keyok && preok && ((hold_q[idx_q] == '0) || lt)) begin
              notify    = 1'b1;
              res_d.act = kcm_pkg::ACT_UP;
            end
          end
          kcm_pkg::OP_CANCEL: clr_tmr = 1'b1;
          kcm_pkg::OP_TICK: begin
            if (sv && ton_q[idx_q]) begin
              dec = 1'b1;
              if (remm1 == '0) begin
                notify    = 1'b1;
                res_d.key = ekey_q[idx_q];
                res_d.tim = etime_q[idx_q];
              end
            end
          end
          kcm_pkg::OP_SUBSCRIBE: begin
            if (!cmd_q.cnt_bad && (cmd_q.cnt <= kcm_pkg::CntW'(MaxPre)) && !done_q && !sv) begin
              wr_slot = 1'b1;
              done_d  = 1'b1;
            end
          end
          kcm_pkg::OP_UNSUB: begin
            if (!done_q && sv && (id_q[idx_q] == cmd_q.id) && (sess_q[idx_q] == cmd_q.sess)) begin
              free   = 1'b1;
              done_d = 1'b1;
            end
          end
          kcm_pkg::OP_DROP: begin
            if (sv && (sess_q[idx_q] == cmd_q.sess)) begin
              free = 1'b1;
            end
          end
          default: ;
        endcase
        if (notify) begin
          rv_d = 1'b1;
          if (cmd_q.op != kcm_pkg::OP_TICK) begin
            handled_d = 1'b1;
          end
        end
        if (idx_q == SW'(Slots - 1)) begin
          state_d = kcm_pkg::BE_CLOSE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      kcm_pkg::BE_CLOSE: begin
        rv_d       = 1'b1;
        res_d      = '0;
        res_d.kind = kcm_pkg::KIND_CLOSE;
        res_d.last = 1'b1;
        res_d.handled = handled_q && ((cmd_q.op == kcm_pkg::OP_KEY_DOWN) ||
                                      (cmd_q.op == kcm_pkg::OP_KEY_UP));
        case (cmd_q.op)
          kcm_pkg::OP_SUBSCRIBE: begin
            if (cmd_q.cnt_bad || (cmd_q.cnt > kcm_pkg::CntW'(MaxPre))) begin
              res_d.status = kcm_pkg::ST_TOO_MANY;
            end else if (!done_q) begin
              res_d.status = kcm_pkg::ST_FULL;
            end
          end
          kcm_pkg::OP_UNSUB: begin
            if (!done_q) begin
              res_d.status = kcm_pkg::ST_NOT_FND;
            end
          end
          default: ;
        endcase
        state_d = kcm_pkg::BE_IDLE;
      end
      default: state_d = kcm_pkg::BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kcm_pkg::BE_IDLE;
      idx_q     <= '0;
      handled_q <= 1'b0;
      done_q    <= 1'b0;
      rv_q      <= 1'b0;
      valid_q   <= '0;
      ton_q     <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      handled_q <= handled_d;
      done_q    <= done_d;
      rv_q      <= rv_d;
      if (wr_slot) begin
        valid_q[idx_q] <= 1'b1;
        ton_q[idx_q]   <= 1'b0;
      end
      if (free || clr_tmr) begin
        ton_q[idx_q] <= 1'b0;
      end
      if (free) begin
        valid_q[idx_q] <= 1'b0;
      end
      if (arm) begin
        ton_q[idx_q] <= 1'b1;
      end
      if (dec && (remm1 == '0)) begin
        ton_q[idx_q] <= 1'b0;
      end
    end
  end

  // remaining count has a defined reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Slots; s++) begin
        rem_q[s] <= '0;
      end
    end else if (wr_slot || free || clr_tmr) begin
      rem_q[idx_q] <= '0;
    end else if (arm) begin
      rem_q[idx_q] <= hold_q[idx_q];
    end else if (dec) begin
      rem_q[idx_q] <= remm1;
    end
  end

  // slot payload, command and result registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (wr_slot) begin
      id_q[idx_q]    <= cmd_q.id;
      sess_q[idx_q]  <= cmd_q.sess;
      fkey_q[idx_q]  <= cmd_q.key;
      press_q[idx_q] <= cmd_q.press;
      hold_q[idx_q]  <= cmd_q.tval;
      pre_q[idx_q]   <= {cmd_q.key_d, cmd_q.key_c, cmd_q.key_b, cmd_q.key_a};
      pcnt_q[idx_q]  <= cmd_q.cnt;
    end
    if (arm) begin
      ekey_q[idx_q]  <= cmd_q.key;
      etime_q[idx_q] <= cmd_q.tval;
    end
    res_q <= res_d;
  end

  assign res_vld_o = rv_q;
  assign res_o     = res_q;
endmodule
`default_nettype wire

### rtl/key_combination_matcher.sv
`default_nettype none
// Channel   | Handshake         | Ports
// command   | start / busy      | operation_i .. down_time_i
// result    | strobe_o          | kind_o .. last_o
//
// In the back end each command is first taken from the queue, then every slot of the
// table scan is visited in turn, and last the closing status is given; the scan of the
// slot table sets the rate. Each result leaves in the cycle after its slot is visited.
// Commands queue in a two-entry buffer, so busy rises only when it is full.
// Reset clears the table valid bits, timers and queue at once; no sweep.
// Results are shown for one cycle each; the receiver cannot stall them.
module key_combination_matcher #(
  parameter int unsigned SLOTS   = 8,
  parameter int unsigned MAX_PRE = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation_i,
  input  wire logic [15:0] key_code_i,
  input  wire logic [15:0] key_a_i,
  input  wire logic [15:0] key_b_i,
  input  wire logic [15:0] key_c_i,
  input  wire logic [15:0] key_d_i,
  input  wire logic [2:0]  key_count_i,
  input  wire logic [7:0]  session_i,
  input  wire logic [15:0] sub_id_i,
  input  wire logic        fire_on_press_i,
  input  wire logic [31:0] time_value_i,
  input  wire logic [31:0] down_time_i,
  output logic             strobe_o,
  output logic             kind_o,
  output logic [15:0]      out_sub_id_o,
  output logic [7:0]       out_session_o,
  output logic [15:0]      out_key_o,
  output logic             out_action_o,
  output logic [31:0]      out_time_o,
  output logic             handled_o,
  output logic [1:0]       status_o,
  output logic             last_o
);
  kcm_pkg::cmd_t cmd_in, cmd_q;
  kcm_pkg::res_t res;
  logic          full, avail, pop, push;

  always_comb begin
    cmd_in         = '0;
    cmd_in.op      = kcm_pkg::op_e'(operation_i);
    cmd_in.key     = key_code_i;
    cmd_in.key_a   = key_a_i;
    cmd_in.key_b   = key_b_i;
    cmd_in.key_c   = key_c_i;
    cmd_in.key_d   = key_d_i;
    cmd_in.cnt     = key_count_i;
    cmd_in.sess    = session_i;
    cmd_in.id      = sub_id_i;
    cmd_in.press   = fire_on_press_i;
    cmd_in.tval    = time_value_i;
    cmd_in.dtime   = down_time_i;
  end

  assign busy = full;
  assign push = start && !full;

  kcm_front #(.Depth(2)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .cmd_o   (cmd_q)
  );

  kcm_back #(.Slots(SLOTS), .MaxPre(MAX_PRE)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .avail_i   (avail),
    .cmd_i     (cmd_q),
    .pop_o     (pop),
    .res_vld_o (strobe_o),
    .res_o     (res)
  );

  assign kind_o        = res.kind;
  assign out_sub_id_o  = res.id;
  assign out_session_o = res.sess;
  assign out_key_o     = res.key;
  assign out_action_o  = res.act;
  assign out_time_o    = res.tim;
  assign handled_o     = res.handled;
  assign status_o      = res.status;
  assign last_o        = res.last;
endmodule
`default_nettype wire
